// ----- sv/hpfc_pkg.sv -----
// ----------------------------------------------------------------------------
// hpfc_pkg
// mode codes and constants for the half precision format converter
// ----------------------------------------------------------------------------
package hpfc_pkg;

  typedef enum logic [2:0] {
    MODE_U32_TO_HALF = 3'd0,
    MODE_S32_TO_HALF = 3'd1,
    MODE_F32_TO_HALF = 3'd2,
    MODE_HALF_TO_U32 = 3'd3,
    MODE_HALF_TO_S32 = 3'd4,
    MODE_HALF_TO_F32 = 3'd5
  } mode_t;

  localparam logic [15:0] HALF_INF     = 16'h7c00;
  localparam logic [15:0] HALF_MAX     = 16'h7bff;
  localparam logic [31:0] INT_POS_LIM  = 32'd65519;
  localparam logic [31:0] INT_NEG_LIM  = 32'd65520;
  localparam logic [31:0] F_OVF_POS    = 32'h477fefff;
  localparam logic [31:0] F_OVF_NEG    = 32'h477ff000;
  localparam logic [31:0] F_NORM_MIN   = 32'h38800000;
  localparam logic [31:0] F_SUB_MIN    = 32'h33000000;
  localparam logic [31:0] F_BIAS_POS   = 32'hc8001000;
  localparam logic [31:0] F_BIAS_NEG   = 32'hc8000fff;
  localparam logic [31:0] F_EXP_ADJ    = 32'h38000000;

  // index of the top set bit, 0 for zero
  function automatic logic [4:0] msb_index(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 1; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

// ----- sv/half_precision_format_converter.sv -----
// ----------------------------------------------------------------------------
// half_precision_format_converter
// converts one 32-bit operand per request between binary16 and u32/s32/f32
// ----------------------------------------------------------------------------
// Usage:
//   input channel carries mode, operand and clamp_to_finite with in_valid and
//   in_stall; the output channel carries converted with out_valid and
//   out_stall. Every request gives exactly one result.
//   A request is captured into an input register, converted by one pass of
//   combinational logic and written into the result register; out_valid
//   rises as the result is written. One request is taken every cycle while
//   out_stall is low; the rate is set by the single conversion pass between
//   the two registers.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_stall rises only when both are full and out_stall is
//   high, so the pipeline drains without loss.
//   Reset clears both valid flags; no result is pending after reset.
//   Modes 6 and 7 give converted = 0.
// ----------------------------------------------------------------------------
module half_precision_format_converter
  import hpfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [31:0] operand,
  input  logic        clamp_to_finite,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] converted
);

  logic        s_valid;
  logic [2:0]  s_mode;
  logic [31:0] s_op;
  logic        s_clamp;
  logic [31:0] res_next;
  logic        s_move;

  assign s_move   = s_valid && (!out_valid || !out_stall);
  assign in_stall = s_valid && !s_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) s_valid <= 1'b1;
      else if (s_move)           s_valid <= 1'b0;
      if (s_move)                out_valid <= 1'b1;
      else if (!out_stall)       out_valid <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      s_mode  <= mode;
      s_op    <= operand;
      s_clamp <= clamp_to_finite;
    end
    if (s_move) converted <= res_next;
  end

  // integer magnitude (1..65520) to half
  function automatic logic [15:0] int_to_half(input logic [16:0] mag, input logic tie_up);
    logic [4:0]  p;
    logic [5:0]  ex;
    logic [32:0] v;
    p  = msb_index({15'd0, mag});
    ex = 6'd15 + {1'b0, p};
    v  = ({16'd0, mag} << (5'd15 - p)) + (tie_up ? 33'h10 : 33'h0f);
    if (v > 33'hffff) begin
      ex = ex + 6'd1;
      v  = v >> 1;
    end
    return 16'(({10'd0, ex} << 10) + {6'd0, v[14:5]});
  endfunction

  function automatic logic [15:0] f32_to_half(input logic [31:0] b, input logic cl);
    logic        neg;
    logic [30:0] mag;
    logic [15:0] sgn;
    logic [31:0] r;
    logic [9:0]  pay;
    logic [7:0]  ex;
    logic [24:0] sig;
    logic [24:0] hf;
    logic [25:0] sum;
    neg = b[31];
    mag = b[30:0];
    sgn = {neg, 15'd0};
    pay = mag[22:13];
    ex  = mag[30:23];
    sig = {2'b01, mag[22:0]};
    hf  = 25'd1 << (8'd125 - ex);
    sum = {1'b0, sig} + {1'b0, (neg ? hf - 25'd1 : hf)};
    if (mag > 31'h7f800000) begin
      return sgn | HALF_INF | {6'd0, (pay == 10'd0) ? 10'h200 : pay};
    end else if ({1'b0, mag} > (neg ? F_OVF_NEG : F_OVF_POS)) begin
      return sgn | (cl ? HALF_MAX : HALF_INF);
    end else if ({1'b0, mag} >= F_NORM_MIN) begin
      r = {1'b0, mag} + (neg ? F_BIAS_NEG : F_BIAS_POS);
      return sgn | {1'b0, r[27:13]};
    end else if ({1'b0, mag} >= F_SUB_MIN) begin
      r = 32'(sum >> (8'd126 - ex));
      return sgn | {1'b0, r[14:0]};
    end
    return sgn;
  endfunction

  function automatic logic [31:0] half_to_int(input logic [15:0] h, input logic tie_up);
    logic [10:0] sig;
    logic [4:0]  sh;
    logic [27:0] v;
    sig = {1'b1, h[9:0]};
    sh  = h[14:10] - 5'd14;
    v   = ({17'd0, sig} << sh) + (tie_up ? 28'h400 : 28'h3ff);
    return {15'd0, v[27:11]};
  endfunction

  function automatic logic [31:0] half_to_f32(input logic [15:0] h);
    logic [31:0] o;
    logic [4:0]  p;
    o = {h[15], 31'd0};
    p = msb_index({22'd0, h[9:0]});
    if (h[14:10] == 5'h1f) return o + 32'h7f800000 + {9'd0, h[9:0], 13'd0};
    if (h[14:10] != 5'd0)  return o + F_EXP_ADJ + {4'd0, h[14:0], 13'd0};
    if (h[9:0] != 10'd0)
      return o + ({24'd0, 8'd103 + {3'd0, p}} << 23)
               + ({22'd0, h[9:0]} << (5'd23 - p) & 32'h007fffff);
    return o;
  endfunction

  logic [15:0] hh;
  logic [31:0] nmag;
  assign hh   = s_op[15:0];
  assign nmag = 32'd0 - s_op;

  always_comb begin
    res_next = 32'd0;
    case (s_mode)
      MODE_U32_TO_HALF: begin
        if (s_op == 32'd0)             res_next = 32'd0;
        else if (s_op > INT_POS_LIM)   res_next = {16'd0, s_clamp ? HALF_MAX : HALF_INF};
        else                           res_next = {16'd0, int_to_half(s_op[16:0], 1'b1)};
      end
      MODE_S32_TO_HALF: begin
        if (s_op == 32'd0) res_next = 32'd0;
        else if (s_op[31]) begin
          if (nmag > INT_NEG_LIM)
            res_next = {16'd0, 1'b1, (s_clamp ? HALF_MAX[14:0] : HALF_INF[14:0])};
          else
            res_next = {16'd0, 16'h8000 | int_to_half(nmag[16:0], 1'b0)};
        end else if (s_op > INT_POS_LIM)
          res_next = {16'd0, s_clamp ? HALF_MAX : HALF_INF};
        else
          res_next = {16'd0, int_to_half(s_op[16:0], 1'b1)};
      end
      MODE_F32_TO_HALF: res_next = {16'd0, f32_to_half(s_op, s_clamp)};
      MODE_HALF_TO_U32: begin
        if (hh < 16'h3800 || hh > HALF_INF) res_next = 32'd0;
        else if (hh == HALF_INF)           res_next = 32'hffffffff;
        else                               res_next = half_to_int(hh, 1'b1);
      end
      MODE_HALF_TO_S32: begin
        if (hh[15]) begin
          if (hh <= 16'hb800 || hh > 16'hfc00) res_next = 32'd0;
          else if (hh == 16'hfc00)            res_next = 32'h80000000;
          else                                res_next = 32'd0 - half_to_int(hh, 1'b0);
        end else begin
          if (hh < 16'h3800 || hh > HALF_INF) res_next = 32'd0;
          else if (hh == HALF_INF)           res_next = 32'h7fffffff;
          else                               res_next = half_to_int(hh, 1'b1);
        end
      end
      MODE_HALF_TO_F32: res_next = half_to_f32(hh);
      default:          res_next = 32'd0;
    endcase
  end

  // a stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(converted))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s_valid && out_valid)
    else $error("input stalled without a full pipeline");

  assert property (@(posedge clk) disable iff (rst)
    s_valid && !out_stall |=> out_valid)
    else $error("staged request did not reach the output");

endmodule
